[rtl/spcp_pkg.sv]
// shared types and constants of the servo position command parser
package spcp_pkg;

	// result action codes
	localparam logic [1:0] ACT_HORIZONTAL = 2'd0;
	localparam logic [1:0] ACT_VERTICAL   = 2'd1;
	localparam logic [1:0] ACT_NOOP       = 2'd2;
	localparam logic [1:0] ACT_ERROR      = 2'd3;

	// command characters
	localparam logic [7:0] CH_TERM = 8'h3B; // ';'
	localparam logic [7:0] CH_W    = 8'h77; // 'w'
	localparam logic [7:0] CH_R    = 8'h72; // 'r'
	localparam logic [7:0] CH_H    = 8'h48; // 'H'
	localparam logic [7:0] CH_V    = 8'h56; // 'V'
	localparam logic [7:0] CH_S    = 8'h53; // 'S'
	localparam logic [7:0] CH_P    = 8'h70; // 'p'
	localparam logic [7:0] CH_D    = 8'h64; // 'd'
	localparam logic [7:0] CH_T    = 8'h74; // 't'

	// digit extraction and decimal weights
	localparam logic [7:0]  DIGIT_MASK = 8'h0F;
	localparam logic [15:0] W_THOUSAND = 16'd1000;
	localparam logic [15:0] W_HUNDRED  = 16'd100;
	localparam logic [15:0] W_TEN      = 16'd10;

	// decoded position is at most 16665
	localparam int POS_W = 15;

	// decoded command passed from front to back
	typedef struct packed {
		logic [1:0]       action;
		logic [POS_W-1:0] position;
	} spcp_cmd_t;

endpackage

[rtl/servo_position_command_parser_core.sv]
// top level of the servo position command parser
// Input channel: one received serial byte per request (in_valid, in_stall,
// rx_byte). Bytes other than ';' fill the command buffer; excess bytes are
// dropped once BUFFER_DEPTH bytes are held. A ';' on a non-empty buffer
// decodes the command and yields one result request; a ';' on an empty
// buffer yields nothing.
// Output channel: out_valid, out_stall, action, pulse_width,
// previous_position. No-op and syntax error results carry zero fields.
// Configuration: cfg_we with cfg_data writes the pulse offset (reset 2000);
// write only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The result is
// queued when the ';' is accepted and loaded into the output register on pop.
// A two entry queue parts the byte front end from the result back end; a
// stalled output holds its result while bytes keep arriving, and the input
// stalls only when the queue is full.
// Reset clears the buffer, write index, both axis compares and the queue.
module servo_position_command_parser_core #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic [15:0] pulse_width,
	output logic [15:0] previous_position,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	import spcp_pkg::*;

	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;
	spcp_cmd_t q_push_data;
	spcp_cmd_t q_head;

	// byte capture and classification
	spcp_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_push_data(q_push_data)
	);

	// decoupling queue
	spcp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_head),
		.empty    (q_empty)
	);

	// command execution
	spcp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data),
		.q_empty          (q_empty),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.action           (action),
		.pulse_width      (pulse_width),
		.previous_position(previous_position)
	);

	// no push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("command pushed into full queue");

	// no pop from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("command popped from empty queue");

	// a full queue holds off the input
	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> in_stall)
		else $error("input not stalled while queue full");

	// no-op and error results carry zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_NOOP || action == ACT_ERROR)
		|-> pulse_width == 16'd0 && previous_position == 16'd0)
		else $error("non-set result with nonzero fields");

endmodule

[rtl/spcp_front.sv]
// front end: byte capture, command buffer and command classification
module spcp_front #(
	parameter int BUFFER_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        rx_byte,
	input  logic              q_full,
	output logic              q_push,
	output spcp_pkg::spcp_cmd_t q_push_data
);
	import spcp_pkg::*;

	localparam int IW = $clog2(BUFFER_DEPTH + 1);
	// only entries 0 to 8 are ever decoded
	localparam int KEEP = 9;

	logic [IW-1:0] index_q;
	logic [7:0]    buf_q [KEEP];
	logic          accept;
	logic          is_term;
	logic          full;
	logic [15:0]   pos_sum;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign is_term  = (rx_byte == CH_TERM);
	assign full     = (index_q == IW'(BUFFER_DEPTH));
	assign q_push   = accept && is_term && (index_q != '0);

	// write index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (accept) begin
			if (is_term) begin
				index_q <= '0;
			end else if (!full) begin
				index_q <= index_q + IW'(1);
			end
		end
	end

	// stored bytes, stale contents survive between commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEEP; i++) begin
				buf_q[i] <= '0;
			end
		end else if (accept && !is_term) begin
			for (int i = 0; i < KEEP; i++) begin
				if (index_q == IW'(i)) begin
					buf_q[i] <= rx_byte;
				end
			end
		end
	end

	// decimal position from low nibbles of bytes 5 to 8
	assign pos_sum = 16'(buf_q[5] & DIGIT_MASK) * W_THOUSAND
	               + 16'(buf_q[6] & DIGIT_MASK) * W_HUNDRED
	               + 16'(buf_q[7] & DIGIT_MASK) * W_TEN
	               + 16'(buf_q[8] & DIGIT_MASK);

	// classify the command
	always_comb begin
		q_push_data.position = pos_sum[POS_W-1:0];
		q_push_data.action   = ACT_ERROR;
		if (buf_q[0] == CH_W) begin
			if (buf_q[2] == CH_H || buf_q[2] == CH_V) begin
				if (buf_q[3] != CH_P) begin
					q_push_data.action = ACT_ERROR;
				end else if (buf_q[2] == CH_H) begin
					q_push_data.action = ACT_HORIZONTAL;
				end else begin
					q_push_data.action = ACT_VERTICAL;
				end
			end else if (buf_q[2] == CH_S) begin
				q_push_data.action = ACT_NOOP;
			end
		end else if (buf_q[0] == CH_R) begin
			if (buf_q[2] == CH_D || buf_q[2] == CH_T) begin
				q_push_data.action = ACT_NOOP;
			end
		end
	end

endmodule

[rtl/spcp_queue.sv]
// two entry command queue between front and back
module spcp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  spcp_pkg::spcp_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output spcp_pkg::spcp_cmd_t pop_data,
	output logic                empty
);
	import spcp_pkg::*;

	spcp_cmd_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/spcp_back.sv]
// back end: axis compare registers, offset register and output register
module spcp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  logic                q_empty,
	input  spcp_pkg::spcp_cmd_t q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          action,
	output logic [15:0]         pulse_width,
	output logic [15:0]         previous_position
);
	import spcp_pkg::*;

	logic [15:0] offset_q;
	logic [15:0] h_cmp_q;
	logic [15:0] v_cmp_q;
	logic        out_valid_q;
	logic [1:0]  action_q;
	logic [15:0] pulse_width_q;
	logic [15:0] prev_pos_q;
	logic [15:0] new_cmp;

	assign q_pop   = !q_empty && (!out_valid_q || !out_stall);
	assign new_cmp = offset_q + 16'(q_head.position);

	// pulse offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 16'd2000;
		end else if (cfg_we) begin
			offset_q <= cfg_data;
		end
	end

	// axis compare registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_cmp_q <= '0;
			v_cmp_q <= '0;
		end else if (q_pop) begin
			if (q_head.action == ACT_HORIZONTAL) begin
				h_cmp_q <= new_cmp;
			end
			if (q_head.action == ACT_VERTICAL) begin
				v_cmp_q <= new_cmp;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			action_q <= q_head.action;
			case (q_head.action)
				ACT_HORIZONTAL: begin
					pulse_width_q <= new_cmp;
					prev_pos_q    <= h_cmp_q - offset_q;
				end
				ACT_VERTICAL: begin
					pulse_width_q <= new_cmp;
					prev_pos_q    <= v_cmp_q - offset_q;
				end
				default: begin
					pulse_width_q <= '0;
					prev_pos_q    <= '0;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign action            = action_q;
	assign pulse_width       = pulse_width_q;
	assign previous_position = prev_pos_q;

endmodule

[bench/servo_position_command_parser_core_test.sv]
// self-checking bench for the servo position command parser: random command streams under stalls
`timescale 1ns / 100ps

module servo_position_command_parser_core_test;
	import spcp_pkg::*;

	localparam int BUF_DEPTH      = 16;
	localparam int PHASE_BYTES    = 275;
	localparam int RESULT_LATENCY = 2;
	localparam int HOLD_CYCLES    = 400;

	// one decoded result as seen on the output channel
	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] pulse_width;
		logic [15:0] prev_pos;
	} servo_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  action;
	logic [15:0] pulse_width;
	logic [15:0] previous_position;
	logic        cfg_we;
	logic [15:0] cfg_data;

	// stimulus and scoreboard
	logic [7:0]    pending_bytes[$];
	servo_result_t expected_results[$];
	servo_result_t oldest_result;
	logic          byte_taken;
	logic          hold_active;
	int            send_idle_pct;
	int            recv_stall_pct;
	int            bytes_queued;
	int            bytes_taken;
	int            results_checked;
	int            failures;
	int            offsets_used;
	int            stall_run;
	int            longest_stall_run;
	int            action_seen[4];

	// predictor state
	logic [7:0]  cmd_buf[BUF_DEPTH];
	int          fill_count;
	logic [15:0] h_cmp;
	logic [15:0] v_cmp;
	logic [15:0] offset_now;

	servo_position_command_parser_core #(
		.BUFFER_DEPTH(BUF_DEPTH)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.rx_byte          (rx_byte),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.action           (action),
		.pulse_width      (pulse_width),
		.previous_position(previous_position),
		.cfg_we           (cfg_we),
		.cfg_data         (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// decimal position from the low nibbles of bytes 5..8
	function automatic logic [15:0] buffered_position();
		int p;
		p = int'(cmd_buf[5][3:0]) * 1000 + int'(cmd_buf[6][3:0]) * 100
		  + int'(cmd_buf[7][3:0]) * 10 + int'(cmd_buf[8][3:0]);
		return 16'(p);
	endfunction

	// update the predicted parser state with one accepted byte
	task automatic parse_byte(input logic [7:0] b);
		servo_result_t r;
		logic [15:0]   pos;
		logic          is_w;
		r = '0;
		if (b == CH_TERM) begin
			if (fill_count != 0) begin
				pos = buffered_position();
				is_w = (cmd_buf[0] == CH_W);
				if (is_w && cmd_buf[2] == CH_H && cmd_buf[3] == CH_P) begin
					r.action = ACT_HORIZONTAL;
					r.prev_pos = h_cmp - offset_now;
					h_cmp = offset_now + pos;
					r.pulse_width = h_cmp;
				end else if (is_w && cmd_buf[2] == CH_V && cmd_buf[3] == CH_P) begin
					r.action = ACT_VERTICAL;
					r.prev_pos = v_cmp - offset_now;
					v_cmp = offset_now + pos;
					r.pulse_width = v_cmp;
				end else if ((is_w && cmd_buf[2] == CH_S) || (cmd_buf[0] == CH_R
						&& (cmd_buf[2] == CH_D || cmd_buf[2] == CH_T))) begin
					r.action = ACT_NOOP;
				end else begin
					r.action = ACT_ERROR;
				end
				expected_results.push_back(r);
				fill_count = 0;
			end
		end else if (fill_count < BUF_DEPTH) begin
			cmd_buf[fill_count] = b;
			fill_count++;
		end
	endtask

	// sender: next byte at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || byte_taken)) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte <= pending_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
				rx_byte <= 8'($urandom_range(255));
			end
		end
	end

	// receiver stall, forced high during a hold-off
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
	end

	// accepted requests on both channels
	always @(posedge clk) begin
		byte_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid) begin
			if (in_stall) begin
				stall_run++;
				if (stall_run > longest_stall_run)
					longest_stall_run = stall_run;
			end else begin
				stall_run = 0;
				bytes_taken++;
				parse_byte(rx_byte);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: action %0d pulse_width %0d previous_position %0d",
					action, pulse_width, previous_position);
				failures++;
			end else begin
				oldest_result = expected_results.pop_front();
				results_checked++;
				action_seen[oldest_result.action]++;
				if (action !== oldest_result.action) begin
					$error("action: expected %0d, got %0d", oldest_result.action, action);
					failures++;
				end
				if (pulse_width !== oldest_result.pulse_width) begin
					$error("pulse_width: expected %0d, got %0d",
						oldest_result.pulse_width, pulse_width);
					failures++;
				end
				if (previous_position !== oldest_result.prev_pos) begin
					$error("previous_position: expected %0d, got %0d",
						oldest_result.prev_pos, previous_position);
					failures++;
				end
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	// any byte except the terminator
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CH_TERM)
			b = ~b;
		return b;
	endfunction

	// mostly ascii digits, sometimes any byte so nibbles above nine show up
	function automatic logic [7:0] digit_byte();
		if ($urandom_range(3) == 0)
			return body_byte();
		return 8'h30 + 8'($urandom_range(9));
	endfunction

	// command letters, biased so short commands hit stale-byte decoding
	function automatic logic [7:0] letter_byte();
		case ($urandom_range(8))
			0: return CH_W;
			1: return CH_R;
			2: return CH_H;
			3: return CH_V;
			4: return CH_S;
			5: return CH_P;
			6: return CH_D;
			7: return CH_T;
			default: return body_byte();
		endcase
	endfunction

	// wH / wV position write, possibly with a bad sub byte or trailing bytes
	task automatic queue_position_write(input int extra);
		int i;
		queue_byte(CH_W);
		queue_byte(body_byte());
		queue_byte($urandom_range(1) ? CH_H : CH_V);
		queue_byte($urandom_range(15) == 0 ? body_byte() : CH_P);
		queue_byte(body_byte());
		for (i = 0; i < 4; i++)
			queue_byte(digit_byte());
		for (i = 0; i < extra; i++)
			queue_byte(body_byte());
	endtask

	// one random command, mostly well formed
	task automatic queue_command();
		int pick;
		int len;
		int i;
		int sel;
		pick = $urandom_range(99);
		if (pick < 40) begin
			queue_position_write($urandom_range(3) == 0 ? $urandom_range(6) : 0);
			queue_byte(CH_TERM);
		end else if (pick < 55) begin
			// no-op commands
			sel = $urandom_range(2);
			queue_byte(sel == 0 ? CH_W : CH_R);
			queue_byte(body_byte());
			queue_byte(sel == 0 ? CH_S : (sel == 1 ? CH_D : CH_T));
			len = $urandom_range(8);
			for (i = 0; i < len; i++)
				queue_byte(body_byte());
			queue_byte(CH_TERM);
		end else if (pick < 70) begin
			// short commands decode against stale bytes
			len = $urandom_range(1, 8);
			for (i = 0; i < len; i++)
				queue_byte(letter_byte());
			queue_byte(CH_TERM);
		end else if (pick < 80) begin
			// buffer overflow, excess bytes dropped
			queue_position_write($urandom_range(8, 15));
			queue_byte(CH_TERM);
		end else if (pick < 90) begin
			len = $urandom_range(1, BUF_DEPTH);
			for (i = 0; i < len; i++)
				queue_byte(body_byte());
			queue_byte(CH_TERM);
		end else if (pick < 95) begin
			// terminators on an empty buffer
			len = $urandom_range(1, 2);
			for (i = 0; i < len; i++)
				queue_byte(CH_TERM);
		end else begin
			len = $urandom_range(1, 3);
			for (i = 0; i < len; i++)
				queue_byte(8'($urandom_range(255)));
		end
	endtask

	// wait for all bytes taken and all results seen, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		while (bytes_taken != bytes_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (RESULT_LATENCY + 3) @(posedge clk);
	endtask

	task automatic write_offset(input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		offset_now = value;
		offsets_used++;
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input bit hold_off);
		int start;
		@(posedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (hold_off) begin
			fork
				begin
					hold_active = 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_active = 1'b0;
				end
			join_none
		end
		start = bytes_queued;
		while (bytes_queued - start < PHASE_BYTES)
			queue_command();
	endtask

	// main sequence
	initial begin
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 16'h0000;
		arst_n = 1'b0;
		byte_taken = 1'b0;
		hold_active = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_queued = 0;
		bytes_taken = 0;
		results_checked = 0;
		failures = 0;
		offsets_used = 1;
		stall_run = 0;
		longest_stall_run = 0;
		action_seen = '{0, 0, 0, 0};
		for (int i = 0; i < BUF_DEPTH; i++)
			cmd_buf[i] = 8'h00;
		fill_count = 0;
		h_cmp = 16'h0000;
		v_cmp = 16'h0000;
		offset_now = 16'd2000;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty terminator, largest position, stale-byte decodes, no-ops
		@(posedge clk);
		queue_byte(CH_TERM);
		queue_byte(CH_W);
		queue_byte(8'h00);
		queue_byte(CH_H);
		queue_byte(CH_P);
		queue_byte(8'hFF);
		repeat (4) queue_byte(8'h3F);
		queue_byte(CH_TERM);
		queue_byte(CH_W);
		queue_byte(8'hFF);
		queue_byte(CH_V);
		queue_byte(CH_TERM);
		queue_byte(CH_R);
		queue_byte(CH_TERM);
		queue_byte(CH_R);
		queue_byte(8'h00);
		queue_byte(CH_D);
		queue_byte(CH_TERM);
		queue_byte(CH_W);
		queue_byte(8'h20);
		queue_byte(CH_S);
		queue_byte(CH_TERM);
		drain();

		write_offset(16'h0000);
		run_phase(0, 0, 1'b1);
		drain();
		write_offset(16'hFFFF);
		run_phase(70, 0, 1'b0);
		drain();
		write_offset(16'($urandom_range(65535)));
		run_phase(0, 70, 1'b0);
		drain();
		write_offset(16'd2000);
		run_phase(15, 15, 1'b0);
		drain();
		write_offset(16'($urandom_range(65535)));
		run_phase(0, 0, 1'b0);
		drain();
		write_offset(16'h0001);
		run_phase(15, 15, 1'b0);
		drain();
		repeat (10) @(posedge clk);

		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			failures++;
		end
		$display("covered %0d bytes and %0d results: %0d horizontal, %0d vertical, %0d no-op, %0d error",
			bytes_taken, results_checked, action_seen[0], action_seen[1], action_seen[2],
			action_seen[3]);
		$display("under %0d pulse offsets; longest input stall %0d cycles",
			offsets_used, longest_stall_run);
		if (failures == 0) begin
			$display("** servo_position_command_parser_core: PASSED **");
		end else begin
			$display("** servo_position_command_parser_core: FAILED **");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("** servo_position_command_parser_core: FAILED **");
		$finish;
	end

endmodule
